[sv/histogram_2d_binning_assert.svh]
// Assertion macros for the two-dimensional histogram checker.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef HISTOGRAM_2D_BINNING_ASSERT_SVH
`define HISTOGRAM_2D_BINNING_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define H2D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define H2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hist2d_pkg.sv]
// Shared constants, types and helpers of the two-dimensional histogram.
// No dependencies; used by every module of the block but the count RAM.
`timescale 1ns / 1ps
`default_nettype none

package hist2d_pkg;

  localparam int unsigned MaxBinsX  = 64;
  localparam int unsigned MaxBinsY  = 64;
  localparam int unsigned CountW    = 32;
  localparam int unsigned OutCountW = 32;

  localparam int unsigned Cells     = MaxBinsX * MaxBinsY;
  localparam int unsigned CellAddrW = $clog2(Cells);
  localparam int unsigned BinXW     = $clog2(MaxBinsX);
  localparam int unsigned BinYW     = $clog2(MaxBinsY);
  localparam int unsigned BinW      = (BinXW > BinYW) ? BinXW : BinYW;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = SampleW + ScaleW;
  localparam int unsigned BinCntW   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgXLow,
    CfgXHigh,
    CfgYLow,
    CfgYHigh,
    CfgXBins,
    CfgYBins,
    CfgXScale,
    CfgYScale
  } cfg_idx_e;

  typedef enum logic {
    OpFill = 1'b0,
    OpRead = 1'b1
  } op_e;

  // Stage enables from the sequencer to the axis units.
  typedef struct packed {
    logic load;
    logic mul;
  } axis_ctl_t;

  // Bins in use along one axis: zero counts as one, large values clamp to the maximum.
  function automatic logic [BinCntW-1:0] eff_bins(input logic [BinCntW-1:0] reg_val,
                                                  input logic [BinCntW-1:0] max_val);
    logic [BinCntW-1:0] res;
    if (reg_val == '0) begin
      res = BinCntW'(1);
    end else if (reg_val > max_val) begin
      res = max_val;
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/histogram_2d_binning.sv]
// Two-dimensional histogram: bins signed sample pairs and counts them in a memory.
// An accepted item passes the multiply, address and read-modify-write states into the output register.
// One item in flight: a new item is taken once the last is through offset, multiply,
// memory read and write back, and later while a finished result waits to be taken.
// Reset: control and configuration registers return to defaults; a clearing pass over
// all 4096 cells zeroes the count memory before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none

module histogram_2d_binning (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [hist2d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [hist2d_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   opcode_i,
  input  logic signed [hist2d_pkg::SampleW-1:0]  sample_x_i,
  input  logic signed [hist2d_pkg::SampleW-1:0]  sample_y_i,
  input  logic        [hist2d_pkg::BinXW-1:0]    read_bin_x_i,
  input  logic        [hist2d_pkg::BinYW-1:0]    read_bin_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   in_range_o,
  output logic        [hist2d_pkg::BinXW-1:0]    bin_x_o,
  output logic        [hist2d_pkg::BinYW-1:0]    bin_y_o,
  output logic        [hist2d_pkg::OutCountW-1:0] cell_count_o
);
  import hist2d_pkg::*;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StMul,
    StAddr,
    StRmw
  } state_e;

  localparam int unsigned AddrMulW = BinYW + BinCntW;

  // Configuration registers
  logic signed [SampleW-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [BinCntW-1:0]        x_bins_q, y_bins_q;
  logic [ScaleW-1:0]         x_scale_q, y_scale_q;

  state_e               state_q, state_d;
  logic [CellAddrW-1:0] clr_q;
  logic                 out_valid_q;
  logic                 out_in_range_q;
  logic [BinXW-1:0]     out_bin_x_q;
  logic [BinYW-1:0]     out_bin_y_q;
  logic [CountW-1:0]    out_count_q;

  op_e                  op_q;
  logic [BinXW-1:0]     rd_bx_q;
  logic [BinYW-1:0]     rd_by_q;
  logic                 ok_d, ok_q;
  logic [BinXW-1:0]     bx_d, bx_q;
  logic [BinYW-1:0]     by_d, by_q;
  logic [CellAddrW-1:0] addr_d, addr_q;

  logic                 cfg_accept, in_accept, out_free;
  logic [BinCntW-1:0]   nx, ny;
  axis_ctl_t            axis_ctl;
  logic                 x_inside, y_inside;
  logic [BinW-1:0]      x_bin, y_bin;
  logic                 fill_ok, read_ok;
  logic [AddrMulW-1:0]  addr_sum;

  logic                 ram_we, ram_re;
  logic [CellAddrW-1:0] ram_waddr;
  logic [CountW-1:0]    ram_wdata, ram_rdata, count_inc, count_out;
  logic                 rmw_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q   <= '0;
      x_high_q  <= '0;
      y_low_q   <= '0;
      y_high_q  <= '0;
      x_bins_q  <= BinCntW'(MaxBinsX);
      y_bins_q  <= BinCntW'(MaxBinsY);
      x_scale_q <= '0;
      y_scale_q <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgXLow:   x_low_q   <= $signed(cfg_data_i[SampleW-1:0]);
        CfgXHigh:  x_high_q  <= $signed(cfg_data_i[SampleW-1:0]);
        CfgYLow:   y_low_q   <= $signed(cfg_data_i[SampleW-1:0]);
        CfgYHigh:  y_high_q  <= $signed(cfg_data_i[SampleW-1:0]);
        CfgXBins:  x_bins_q  <= cfg_data_i[BinCntW-1:0];
        CfgYBins:  y_bins_q  <= cfg_data_i[BinCntW-1:0];
        CfgXScale: x_scale_q <= cfg_data_i[ScaleW-1:0];
        CfgYScale: y_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign nx = eff_bins(x_bins_q, BinCntW'(MaxBinsX));
  assign ny = eff_bins(y_bins_q, BinCntW'(MaxBinsY));

  assign axis_ctl.load = in_accept;
  assign axis_ctl.mul  = (state_q == StMul);

  hist2d_axis u_axis_x (
    .clk_i    (clk_i),
    .ctl_i    (axis_ctl),
    .sample_i (sample_x_i),
    .low_i    (x_low_q),
    .high_i   (x_high_q),
    .scale_i  (x_scale_q),
    .bins_i   (nx),
    .inside_o (x_inside),
    .bin_o    (x_bin)
  );

  hist2d_axis u_axis_y (
    .clk_i    (clk_i),
    .ctl_i    (axis_ctl),
    .sample_i (sample_y_i),
    .low_i    (y_low_q),
    .high_i   (y_high_q),
    .scale_i  (y_scale_q),
    .bins_i   (ny),
    .inside_o (y_inside),
    .bin_o    (y_bin)
  );

  // Cell selection, resolved in the address stage
  assign fill_ok = x_inside && y_inside;
  assign read_ok = (BinCntW'(rd_bx_q) < nx) && (BinCntW'(rd_by_q) < ny);

  always_comb begin
    if (op_q == OpRead) begin
      ok_d = read_ok;
      bx_d = rd_bx_q;
      by_d = rd_by_q;
    end else begin
      ok_d = fill_ok;
      bx_d = fill_ok ? BinXW'(x_bin) : '0;
      by_d = fill_ok ? BinYW'(y_bin) : '0;
    end
  end

  assign addr_sum = AddrMulW'(by_d) * AddrMulW'(nx) + AddrMulW'(bx_d);
  assign addr_d   = CellAddrW'(addr_sum);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_e'(opcode_i);
      rd_bx_q <= read_bin_x_i;
      rd_by_q <= read_bin_y_i;
    end
    if (state_q == StAddr) begin
      ok_q   <= ok_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      addr_q <= addr_d;
    end
  end

  // Read-modify-write of the count; hold it at the top of its range
  assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + CountW'(1);
  assign rmw_write = (state_q == StRmw) && out_free && ok_q && (op_q == OpFill);

  always_comb begin
    if (!ok_q) begin
      count_out = '0;
    end else if (op_q == OpFill) begin
      count_out = count_inc;
    end else begin
      count_out = ram_rdata;
    end
  end

  assign ram_re    = (state_q == StAddr) && ok_d;
  assign ram_we    = (state_q == StClear) || rmw_write;
  assign ram_waddr = (state_q == StClear) ? clr_q : addr_q;
  assign ram_wdata = (state_q == StClear) ? '0 : count_inc;

  hist2d_count_ram #(
    .Depth (Cells),
    .Width (CountW)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == CellAddrW'(Cells - 1)) state_d = StIdle;
      StIdle:  if (in_accept) state_d = StMul;
      StMul:   state_d = StAddr;
      StAddr:  state_d = StRmw;
      StRmw:   if (out_free) state_d = StIdle;
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      out_in_range_q <= 1'b0;
      out_bin_x_q    <= '0;
      out_bin_y_q    <= '0;
      out_count_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + CellAddrW'(1);
      end
      // Load the result once the output register is free
      if ((state_q == StRmw) && out_free) begin
        out_valid_q    <= 1'b1;
        out_in_range_q <= ok_q;
        out_bin_x_q    <= bx_q;
        out_bin_y_q    <= by_q;
        out_count_q    <= count_out;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_range_o   = out_in_range_q;
  assign bin_x_o      = out_bin_x_q;
  assign bin_y_o      = out_bin_y_q;
  assign cell_count_o = OutCountW'(out_count_q);

endmodule

`default_nettype wire

[sv/hist2d_count_ram.sv]
// Generic single-clock RAM, one write and one read port, registered read data.
// Holds the bin counts; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module hist2d_count_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/hist2d_axis.sv]
// One axis of the binning path: range check, offset, scale multiply, clamp.
// Depends on hist2d_pkg; stepped by the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module hist2d_axis (
  input  logic                                  clk_i,
  input  hist2d_pkg::axis_ctl_t                 ctl_i,
  input  logic signed [hist2d_pkg::SampleW-1:0] sample_i,
  input  logic signed [hist2d_pkg::SampleW-1:0] low_i,
  input  logic signed [hist2d_pkg::SampleW-1:0] high_i,
  input  logic        [hist2d_pkg::ScaleW-1:0]  scale_i,
  input  logic        [hist2d_pkg::BinCntW-1:0] bins_i,
  output logic                                  inside_o,
  output logic        [hist2d_pkg::BinW-1:0]    bin_o
);
  import hist2d_pkg::*;

  logic [SampleW-1:0] diff_d, diff_q;
  logic               inside_d, inside_q;
  logic [ProdW-1:0]   prod_q;
  logic [SampleW-1:0] whole;
  logic [BinCntW-1:0] last_bin;

  // Offset wraps modulo 2^16; it is only used when the sample is inside the range.
  assign diff_d   = $unsigned(sample_i) - $unsigned(low_i);
  assign inside_d = (sample_i >= low_i) && (sample_i < high_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      diff_q   <= diff_d;
      inside_q <= inside_d;
    end
    if (ctl_i.mul) begin
      prod_q <= ProdW'(diff_q) * ProdW'(scale_i);
    end
  end

  // Drop the fraction, then clamp to the last bin in use.
  assign whole    = prod_q[ProdW-1:FracW];
  assign last_bin = bins_i - BinCntW'(1);

  always_comb begin
    if (whole > SampleW'(last_bin)) begin
      bin_o = BinW'(last_bin);
    end else begin
      bin_o = BinW'(whole);
    end
  end

  assign inside_o = inside_q;

endmodule

`default_nettype wire

[sv/hist2d_checker.sv]
// Port-level checks of the two-dimensional histogram, bound to its top level.
// Depends on hist2d_pkg and histogram_2d_binning_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "histogram_2d_binning_assert.svh"

module hist2d_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic                                    in_range_o,
  input logic        [hist2d_pkg::BinXW-1:0]     bin_x_o,
  input logic        [hist2d_pkg::BinYW-1:0]     bin_y_o,
  input logic        [hist2d_pkg::OutCountW-1:0] cell_count_o
);
  import hist2d_pkg::*;

  // A stalled result holds until taken
  `H2D_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cell_count_o) && $stable(bin_x_o) && $stable(bin_y_o) && $stable(in_range_o), "result changed while stalled")

  // A miss never reports a count
  `H2D_ASSERT_SAME(a_miss_zero, out_valid_o && !in_range_o, cell_count_o == '0, "count on a miss")

  // Only one item in flight: busy right after an accept
  `H2D_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule

bind histogram_2d_binning hist2d_checker u_hist2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .in_range_o   (in_range_o),
  .bin_x_o      (bin_x_o),
  .bin_y_o      (bin_y_o),
  .cell_count_o (cell_count_o)
);

`default_nettype wire

[tb/tb_histogram_2d_binning.sv]
// Self-checking testbench for histogram_2d_binning: drives fill and read items
// and register writes, predicts every cell count and bin index, and compares results.
// Depends on hist2d_pkg and the histogram_2d_binning RTL only.
`timescale 1ns / 1ps

module tb_histogram_2d_binning;
  import hist2d_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned PhaseItems = 230;
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic                 in_range;
    logic [BinXW-1:0]     bin_x;
    logic [BinYW-1:0]     bin_y;
    logic [OutCountW-1:0] count;
  } cell_result_t;

  class hist_scoreboard;
    logic signed [SampleW-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [BinCntW-1:0]        x_bins, y_bins;
    logic [ScaleW-1:0]         x_scl, y_scl;
    logic [CountW-1:0]         counts [Cells];
    cell_result_t              awaited_cells [$];
    int                        errors;

    function new();
      x_lo = '0;
      x_hi = '0;
      y_lo = '0;
      y_hi = '0;
      x_bins = BinCntW'(64);
      y_bins = BinCntW'(64);
      x_scl = '0;
      y_scl = '0;
      errors = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function int unsigned bins_in_use(logic [BinCntW-1:0] r, int unsigned lim);
      if (r == '0) return 1;
      if (r > lim) return lim;
      return r;
    endfunction

    function int unsigned axis_bin(logic signed [SampleW-1:0] v, logic signed [SampleW-1:0] lo,
                                   logic [ScaleW-1:0] scl, int unsigned nb);
      logic [SampleW:0] diff;
      logic [31:0]      prod;
      int unsigned      b;
      diff = {v[SampleW-1], v} - {lo[SampleW-1], lo};
      prod = {16'd0, diff[SampleW-1:0]} * {16'd0, scl};
      b = prod[31:FracW];
      if (b > nb - 1) b = nb - 1;
      return b;
    endfunction

    function void load_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CfgXLow:   x_lo = d;
        CfgXHigh:  x_hi = d;
        CfgYLow:   y_lo = d;
        CfgYHigh:  y_hi = d;
        CfgXBins:  x_bins = d[BinCntW-1:0];
        CfgYBins:  y_bins = d[BinCntW-1:0];
        CfgXScale: x_scl = d;
        CfgYScale: y_scl = d;
        default: ;
      endcase
    endfunction

    // Bin or read one item and queue the result it must produce.
    function void count_item(op_e op, logic signed [SampleW-1:0] sx,
                             logic signed [SampleW-1:0] sy,
                             logic [BinXW-1:0] rx, logic [BinYW-1:0] ry);
      cell_result_t r;
      int unsigned  nx, ny, bx, by, cell_idx;
      nx = bins_in_use(x_bins, MaxBinsX);
      ny = bins_in_use(y_bins, MaxBinsY);
      r = '0;
      if (op == OpFill) begin
        if (sx >= x_lo && sx < x_hi && sy >= y_lo && sy < y_hi) begin
          bx = axis_bin(sx, x_lo, x_scl, nx);
          by = axis_bin(sy, y_lo, y_scl, ny);
          cell_idx = by * nx + bx;
          if (counts[cell_idx] != '1) counts[cell_idx] = counts[cell_idx] + 1'b1;
          r.in_range = 1'b1;
          r.bin_x = BinXW'(bx);
          r.bin_y = BinYW'(by);
          r.count = counts[cell_idx];
        end
      end else begin
        r.bin_x = rx;
        r.bin_y = ry;
        if (rx < nx && ry < ny) begin
          r.in_range = 1'b1;
          r.count = counts[ry * nx + rx];
        end
      end
      awaited_cells.push_back(r);
    endfunction

    function void match_result(cell_result_t got);
      cell_result_t want;
      if (awaited_cells.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: in_range=%0b bin=(%0d,%0d) count=%0d",
                   got.in_range, got.bin_x, got.bin_y, got.count);
        return;
      end
      want = awaited_cells.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected in_range=%0b bin=(%0d,%0d) count=%0d, got in_range=%0b bin=(%0d,%0d) count=%0d",
                   want.in_range, want.bin_x, want.bin_y, want.count,
                   got.in_range, got.bin_x, got.bin_y, got.count);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic [SampleW-1:0]   sample_x_i;
  logic [SampleW-1:0]   sample_y_i;
  logic [BinXW-1:0]     read_bin_x_i;
  logic [BinYW-1:0]     read_bin_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 in_range_o;
  logic [BinXW-1:0]     bin_x_o;
  logic [BinYW-1:0]     bin_y_o;
  logic [OutCountW-1:0] cell_count_o;

  hist_scoreboard sb = new();
  bit             no_idle = 1'b0;
  bit             hold_req = 1'b0;
  bit             have_prev = 1'b0;
  logic [SampleW-1:0] prev_x, prev_y;
  int unsigned    idle_cycles = 0;

  histogram_2d_binning dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .read_bin_x_i (read_bin_x_i),
    .read_bin_y_i (read_bin_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_range_o   (in_range_o),
    .bin_x_o      (bin_x_o),
    .bin_y_o      (bin_y_o),
    .cell_count_o (cell_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.match_result({in_range_o, bin_x_o, bin_y_o, cell_count_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = no_idle || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic send_item(op_e op, logic [SampleW-1:0] sx, logic [SampleW-1:0] sy,
                           logic [BinXW-1:0] rx, logic [BinYW-1:0] ry);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    sample_x_i = sx;
    sample_y_i = sy;
    read_bin_x_i = rx;
    read_bin_y_i = ry;
    do @(posedge clk_i); while (!in_ready_o);
    sb.count_item(op, sx, sy, rx, ry);
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_fill(logic [SampleW-1:0] sx, logic [SampleW-1:0] sy);
    send_item(OpFill, sx, sy, BinXW'($urandom), BinYW'($urandom));
  endtask

  task automatic send_read(logic [BinXW-1:0] rx, logic [BinYW-1:0] ry);
    send_item(OpRead, SampleW'($urandom), SampleW'($urandom), rx, ry);
  endtask

  // Stop offering items and wait until every outstanding result is out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.awaited_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_setting(int xl, int xh, int yl, int yh,
                               logic [CfgDataW-1:0] xb, logic [CfgDataW-1:0] yb,
                               logic [CfgDataW-1:0] xs, logic [CfgDataW-1:0] ys);
    logic [CfgDataW-1:0] vals [NumRegs];
    int unsigned         start;
    cfg_idx_e            idx;
    settle();
    vals[CfgXLow]   = CfgDataW'(xl);
    vals[CfgXHigh]  = CfgDataW'(xh);
    vals[CfgYLow]   = CfgDataW'(yl);
    vals[CfgYHigh]  = CfgDataW'(yh);
    vals[CfgXBins]  = xb;
    vals[CfgYBins]  = yb;
    vals[CfgXScale] = xs;
    vals[CfgYScale] = ys;
    start = $urandom_range(0, NumRegs - 1);
    for (int k = 0; k < NumRegs; k++) begin
      idx = cfg_idx_e'((start + k) % NumRegs);
      @(negedge clk_i);
      cfg_valid_i = 1'b1;
      cfg_index_i = idx;
      cfg_data_i = vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.load_reg(idx, vals[idx]);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic pick_axis(output int lo, output int hi, input bit tiny);
    int span;
    lo = int'($urandom_range(0, 65000)) - 32768;
    if (tiny) span = $urandom_range(1, 40);
    else if ($urandom_range(0, 1) == 1) span = $urandom_range(1, 400);
    else span = $urandom_range(1, 65535);
    hi = lo + span;
    if (hi > 32767) hi = 32767;
  endtask

  function automatic logic [ScaleW-1:0] scale_for(int unsigned nb, int lo, int hi);
    int unsigned s;
    s = nb * 65536 / (hi - lo);
    if (s > 65535) s = 65535;
    return ScaleW'(s);
  endfunction

  function automatic logic [SampleW-1:0] pick_in(int lo, int hi);
    if (hi > lo) return SampleW'(lo + int'($urandom_range(0, hi - lo - 1)));
    return SampleW'($urandom);
  endfunction

  // Mostly in-range fills with repeats, reads of live cells, and some noise.
  task automatic random_item();
    int unsigned        r, nx, ny;
    logic [SampleW-1:0] x, y;
    nx = sb.bins_in_use(sb.x_bins, MaxBinsX);
    ny = sb.bins_in_use(sb.y_bins, MaxBinsY);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      if (have_prev && $urandom_range(0, 9) == 0) begin
        x = prev_x;
        y = prev_y;
      end else begin
        x = pick_in(int'(sb.x_lo), int'(sb.x_hi));
        y = pick_in(int'(sb.y_lo), int'(sb.y_hi));
      end
      prev_x = x;
      prev_y = y;
      have_prev = 1'b1;
      send_fill(x, y);
    end else if (r < 92) begin
      send_read(BinXW'($urandom_range(0, nx - 1)), BinYW'($urandom_range(0, ny - 1)));
    end else begin
      send_item(op_e'($urandom_range(0, 1)), SampleW'($urandom), SampleW'($urandom),
                BinXW'($urandom), BinYW'($urandom));
    end
  endtask

  task automatic setup_phase(int p);
    int          xl, xh, yl, yh;
    int unsigned xb, yb;
    pick_axis(xl, xh, p == 1);
    pick_axis(yl, yh, p == 1);
    xb = $urandom_range(1, 64);
    yb = $urandom_range(1, 64);
    if (p == 6) begin
      xb = $urandom_range(1, 4);
      yb = $urandom_range(1, 4);
    end
    case (p)
      2: apply_setting(xl, xh, yl, yh, 0, 127, 0, scale_for(64, yl, yh));
      3: apply_setting(-32768, 32767, -32768, 32767, 64, 64,
                       scale_for(64, -32768, 32767), scale_for(64, -32768, 32767));
      // Inverted range on x, empty range on y.
      4: apply_setting(xh, xl, yl, yl, CfgDataW'(xb), CfgDataW'(yb),
                       scale_for(xb, xl, xh), scale_for(yb, yl, yh));
      5: apply_setting($urandom, $urandom, $urandom, $urandom,
                       CfgDataW'($urandom), CfgDataW'($urandom),
                       CfgDataW'($urandom), CfgDataW'($urandom));
      7: apply_setting(xl, xh, yl, yh, CfgDataW'(xb), CfgDataW'(yb),
                       CfgDataW'($urandom), CfgDataW'($urandom));
      default: apply_setting(xl, xh, yl, yh, CfgDataW'(xb), CfgDataW'(yb),
                             scale_for(xb, xl, xh), scale_for(yb, yl, yh));
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgXLow;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = OpFill;
    sample_x_i = '0;
    sample_y_i = '0;
    read_bin_x_i = '0;
    read_bin_y_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: empty ranges, all 64 x 64 cells readable.
    send_fill(16'sd0, 16'sd0);
    send_read(0, 0);
    send_read(63, 63);

    apply_setting(-32768, 32767, -32768, 32767, 64, 64, 16'hFFFF, 16'hFFFF);
    send_fill(16'h8000, 16'h8000);
    send_fill(16'h8000, 16'h8000);
    send_fill(16'h7FFE, 16'h7FFE);
    send_fill(16'h7FFF, 16'h0000);
    send_fill(16'h0000, 16'h7FFF);
    send_fill(16'h0000, 16'h0000);
    send_fill(16'hFFFF, 16'hFFFF);
    send_read(0, 0);
    send_read(63, 63);

    // One x bin with zero scale, oversized y bin count, inverted y range.
    apply_setting(-100, 100, 5, -5, 0, 127, 0, 1024);
    send_fill(16'sd0, 16'sd0);
    send_read(0, 0);
    send_read(1, 0);
    send_read(0, 63);
    apply_setting(-100, 100, -10, 10, 0, 64, 0, 16'hFFFF);
    send_fill(-16'sd100, -16'sd10);
    send_fill(16'sd99, 16'sd9);
    send_fill(-16'sd101, 16'sd0);
    send_read(0, 18);
    send_read(0, 0);

    for (int p = 0; p < 8; p++) begin
      setup_phase(p);
      no_idle = (p == 6);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) random_item();
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_cells.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
